@@ hdl/rc_channel_calibrate_macros.svh @@
// ----------------------------------------------------------------------------
// rc channel calibrate assertion macros
// shared concurrent assertion forms for the calibration block
// ----------------------------------------------------------------------------
`ifndef RC_CHANNEL_CALIBRATE_MACROS_SVH
`define RC_CHANNEL_CALIBRATE_MACROS_SVH

// same-cycle implication
`define RCC_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rcc assertion failed");

// next-cycle implication
`define RCC_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rcc assertion failed");

`endif

@@ hdl/rcc_pkg.sv @@
// ----------------------------------------------------------------------------
// rcc_pkg
// types and constants shared by the channel calibration modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

    localparam int unsigned CHANNELS_DEF = 16;
    localparam int unsigned CH_W         = 4;
    localparam int unsigned SMP_W        = 16;
    localparam int unsigned DIFF_W       = SMP_W + 1;
    localparam int unsigned VAL_W        = 11;
    localparam int unsigned Q_W          = 9;
    localparam int unsigned NUM_W        = SMP_W + Q_W;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    localparam logic [VAL_W-1:0] CENTER = 11'd1500;
    localparam logic [VAL_W-1:0] SAT_HI = 11'd2000;
    localparam logic [VAL_W-1:0] SAT_LO = 11'd1000;
    localparam logic [Q_W-1:0]   SPAN   = 9'd500;

    typedef struct packed {
        logic                    opcode;
        logic [CH_W-1:0]         channel;
        logic signed [SMP_W-1:0] raw_value;
        logic signed [SMP_W-1:0] cal_max;
        logic signed [SMP_W-1:0] cal_min;
        logic signed [SMP_W-1:0] cal_trim;
        logic                    cal_reverse;
    } t_in_word;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [VAL_W-1:0] calibrated_value;
    } t_out_word;

    typedef struct packed {
        logic [SMP_W-1:0] hi;
        logic [SMP_W-1:0] lo;
        logic [SMP_W-1:0] trim;
        logic             rev;
    } t_cal_entry;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic             sat;
        logic [VAL_W-1:0] sat_val;
        logic             neg;
        logic [NUM_W-1:0] rem;
        logic [SMP_W-1:0] den;
        logic [Q_W-1:0]   quo;
    } t_div_word;

endpackage

`default_nettype wire

@@ hdl/rc_channel_calibrate.sv @@
// ----------------------------------------------------------------------------
// rc_channel_calibrate
// endpoint and trim normalization of radio-control channel samples
// ----------------------------------------------------------------------------
// a sample word passes in order through these registered steps after acceptance
// (table read, subtract, magnitude and scale, 9 divider cells, output)
// throughput: one word per cycle while the output is not stalled by i_out_ready,
// set by the one-bit-per-cell divider chain; a sample sees any earlier table write
// reset: synchronous, clears pipeline valid flags; table is undefined until written
`timescale 1ns / 1ps
`default_nettype none
`include "rc_channel_calibrate_macros.svh"

module rc_channel_calibrate #(
    parameter int unsigned CHANNELS = rcc_pkg::CHANNELS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  rcc_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rcc_pkg::t_out_word o_out_word
);
    import rcc_pkg::*;

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic       en;
    logic       acc;
    logic       ch_ok;
    t_cal_entry wr_entry;
    t_cal_entry rd_entry;

    // stage 0
    logic              r_s0_valid;
    logic [CH_W-1:0]   r_s0_ch;
    logic [SMP_W-1:0]  r_s0_raw;

    // stage 1
    logic              r_s1_valid;
    logic [CH_W-1:0]   r_s1_ch;
    logic [DIFF_W-1:0] r_s1_d;
    logic [DIFF_W-1:0] r_s1_div;
    logic              r_s1_rev;
    logic [DIFF_W-1:0] n_s1_d;
    logic [DIFF_W-1:0] n_s1_div;

    // stage 2
    logic              r_s2_valid;
    t_div_word         r_s2_word;
    t_div_word         n_s2_word;
    logic [DIFF_W-1:0] mag_full;
    logic [SMP_W-1:0]  mag;
    logic              d_zero;
    logic              d_pos;
    logic              div_le0;

    // divider chain
    logic              cv [Q_W+1];
    t_div_word         cw [Q_W+1];

    // output
    logic              r_out_valid;
    t_out_word         r_out_word;
    t_out_word         n_out_word;
    logic [VAL_W-1:0]  lin_val;

    assign en         = !r_out_valid || i_out_ready;
    assign o_in_ready = en;
    assign acc        = i_in_valid && en;
    assign ch_ok      = ({1'b0, i_in_word.channel} < (CH_W + 1)'(CHANNELS));

    assign wr_entry.hi   = i_in_word.cal_max;
    assign wr_entry.lo   = i_in_word.cal_min;
    assign wr_entry.trim = i_in_word.cal_trim;
    assign wr_entry.rev  = i_in_word.cal_reverse;

    rcc_cal_table #(
        .WIDTH  ($bits(t_cal_entry)),
        .DEPTH  (CHANNELS),
        .ADDR_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_we      (acc && ch_ok && (i_in_word.opcode == OP_WRITE)),
        .i_wr_addr (i_in_word.channel[IDX_W-1:0]),
        .i_wr_data (wr_entry),
        .i_rd_en   (en),
        .i_rd_addr (i_in_word.channel[IDX_W-1:0]),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en) begin
            r_s0_valid <= acc && ch_ok && (i_in_word.opcode == OP_SAMPLE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_ch  <= i_in_word.channel;
            r_s0_raw <= i_in_word.raw_value;
        end
    end

    // deviation from trim and the divisor for its side
    always_comb begin
        n_s1_d = {r_s0_raw[SMP_W-1], r_s0_raw}
               - {rd_entry.trim[SMP_W-1], rd_entry.trim};
        if (!n_s1_d[DIFF_W-1] && (n_s1_d != '0)) begin
            n_s1_div = {rd_entry.hi[SMP_W-1], rd_entry.hi}
                     - {rd_entry.trim[SMP_W-1], rd_entry.trim};
        end else begin
            n_s1_div = {rd_entry.trim[SMP_W-1], rd_entry.trim}
                     - {rd_entry.lo[SMP_W-1], rd_entry.lo};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_ch  <= r_s0_ch;
            r_s1_d   <= n_s1_d;
            r_s1_div <= n_s1_div;
            r_s1_rev <= rd_entry.rev;
        end
    end

    // magnitude, saturation and scaled numerator
    always_comb begin
        mag_full = r_s1_d[DIFF_W-1] ? (~r_s1_d + DIFF_W'(1)) : r_s1_d;
        mag      = mag_full[SMP_W-1:0];
        d_zero   = (r_s1_d == '0);
        d_pos    = !r_s1_d[DIFF_W-1] && !d_zero;
        div_le0  = r_s1_div[DIFF_W-1] || (r_s1_div == '0);

        n_s2_word.channel = r_s1_ch;
        n_s2_word.sat     = div_le0 || ({1'b0, mag} >= r_s1_div);
        if (d_zero) begin
            n_s2_word.sat_val = CENTER;
        end else if (d_pos ^ r_s1_rev) begin
            n_s2_word.sat_val = SAT_HI;
        end else begin
            n_s2_word.sat_val = SAT_LO;
        end
        n_s2_word.neg = r_s1_d[DIFF_W-1] ^ r_s1_rev;
        n_s2_word.rem = NUM_W'(mag) * NUM_W'(SPAN);
        n_s2_word.den = r_s1_div[SMP_W-1:0];
        n_s2_word.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (en) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_word <= n_s2_word;
        end
    end

    assign cv[0] = r_s2_valid;
    assign cw[0] = r_s2_word;

    for (genvar g = 0; g < Q_W; g++) begin : g_cell
        rcc_div_cell #(
            .SHIFT (Q_W - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (cv[g]),
            .i_word  (cw[g]),
            .o_valid (cv[g+1]),
            .o_word  (cw[g+1])
        );
    end

    // floor toward minus infinity for negative quotients
    always_comb begin
        if (cw[Q_W].neg) begin
            lin_val = CENTER - VAL_W'(cw[Q_W].quo) - VAL_W'(cw[Q_W].rem != '0);
        end else begin
            lin_val = CENTER + VAL_W'(cw[Q_W].quo);
        end
        n_out_word.out_channel      = cw[Q_W].channel;
        n_out_word.calibrated_value = cw[Q_W].sat ? cw[Q_W].sat_val : lin_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `RCC_ASSERT_IMP(a_out_range, i_clk, i_rst_n, o_out_valid, (o_out_word.calibrated_value >= SAT_LO) && (o_out_word.calibrated_value <= SAT_HI))
    `RCC_ASSERT_NXT(a_write_no_word, i_clk, i_rst_n, acc && (i_in_word.opcode == OP_WRITE), !r_s0_valid)
    `RCC_ASSERT_NXT(a_chain_to_out, i_clk, i_rst_n, en && cv[Q_W], o_out_valid)

endmodule

`default_nettype wire

@@ hdl/rcc_cal_table.sv @@
// ----------------------------------------------------------------------------
// rcc_cal_table
// generic single-port-write ram with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcc_cal_table #(
    parameter int unsigned WIDTH  = $bits(rcc_pkg::t_cal_entry),
    parameter int unsigned DEPTH  = rcc_pkg::CHANNELS_DEF,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire               i_clk,
    input  wire               i_we,
    input  wire  [ADDR_W-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]  i_wr_data,
    input  wire               i_rd_en,
    input  wire  [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hdl/rcc_div_cell.sv @@
// ----------------------------------------------------------------------------
// rcc_div_cell
// one restoring division cell, resolves a single quotient bit per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcc_div_cell #(
    parameter int unsigned SHIFT = 0
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  rcc_pkg::t_div_word  i_word,
    output logic                o_valid,
    output rcc_pkg::t_div_word  o_word
);
    import rcc_pkg::*;

    logic [NUM_W-1:0] den_sh;
    logic             fits;
    t_div_word        n_word;
    logic             r_valid;
    t_div_word        r_word;

    always_comb begin
        den_sh = NUM_W'(i_word.den) << SHIFT;
        fits   = (i_word.rem >= den_sh);
        n_word = i_word;
        if (fits) begin
            n_word.rem        = i_word.rem - den_sh;
            n_word.quo[SHIFT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire
